FILE: rtl/core/ssm_pkg.sv
// ssm_pkg: shared constants and types for the sorted sequence merge block.
// No dependencies. Used by ssm_list_ram, ssm_merge_ctrl and sorted_sequence_merge.
package ssm_pkg;

    // List capacity (1..32) and the widths that follow from it.
    localparam int DEPTH   = 32;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;

    // Command codes carried on the mode field.
    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_MERGE  = 2'd2;

    // One cycle's access to a list RAM: optional write plus a read.
    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } t_ram_req;

endpackage

FILE: rtl/core/sorted_sequence_merge.sv
// sorted_sequence_merge: top level of the two-way sorted merge block.
// Depends on ssm_pkg, ssm_list_ram (two instances) and ssm_merge_ctrl.
//   Command channel: a transaction is taken at a rising edge with i_start high
//   and o_busy low. i_mode selects append to list A, append to list B, or
//   merge; i_value is the element to append and is ignored on a merge.
//   Appends never raise o_busy, so loads stream one per cycle while no merge
//   holds o_busy high. An append to a full list (DEPTH entries) is dropped and
//   sets a sticky overflow flag. The unused mode code is ignored.
//   Merge: o_busy stays high until the last entry of both lists is taken.
//   The first result appears once the state register is in the merge state
//   and the result registers hold the first compare, then one per cycle; the
//   RAMs' registered reads set the rate: each cycle compares the two heads,
//   fetches the one taken's successor. On equal heads B's element goes first.
//   Result channel: o_strobe marks each result for exactly one cycle; the
//   receiver cannot stall, there is no backpressure. o_is_last flags the final
//   element, o_overflowed reports the flag as it stood at the merge. A merge
//   of two empty lists gives no result but clears the flag; after a merge
//   both lists are empty and the flag is clear.
//   Reset (synchronous, active low) empties both lists and clears the flag;
//   the RAM contents are not cleared and need not be.
module sorted_sequence_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_mode,
    input  logic signed [ssm_pkg::DATA_W-1:0] i_value,
    output logic                              o_strobe,
    output logic signed [ssm_pkg::DATA_W-1:0] o_merged_value,
    output logic                              o_is_last,
    output logic                              o_overflowed
);

    ssm_pkg::t_ram_req                 req_a, req_b;
    logic signed [ssm_pkg::DATA_W-1:0] head_a, head_b;

    // List stores: read data is the current head of each list during a merge.
    ssm_list_ram u_list_a (
        .i_clk   (i_clk),
        .i_req   (req_a),
        .o_rdata (head_a)
    );

    ssm_list_ram u_list_b (
        .i_clk   (i_clk),
        .i_req   (req_b),
        .o_rdata (head_b)
    );

    // Counters, overflow flag, merge sequencer and result registers.
    ssm_merge_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_busy         (o_busy),
        .o_req_a        (req_a),
        .o_req_b        (req_b),
        .i_head_a       (head_a),
        .i_head_b       (head_b),
        .o_strobe       (o_strobe),
        .o_merged_value (o_merged_value),
        .o_is_last      (o_is_last),
        .o_overflowed   (o_overflowed)
    );

endmodule

FILE: rtl/core/ssm_list_ram.sv
// ssm_list_ram: one list store, one write and one registered read per cycle.
// Depends on ssm_pkg for depth, widths and the request struct.
module ssm_list_ram (
    input  logic                             i_clk,
    input  ssm_pkg::t_ram_req                i_req,
    output logic signed [ssm_pkg::DATA_W-1:0] o_rdata
);

    logic signed [ssm_pkg::DATA_W-1:0] r_mem [ssm_pkg::DEPTH];
    logic signed [ssm_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ssm_merge_ctrl.sv
// ssm_merge_ctrl: list fill counters, overflow flag and the merge sequencer.
// Depends on ssm_pkg; drives two ssm_list_ram instances through t_ram_req.
module ssm_merge_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [1:0]                        i_mode,
    input  logic signed [ssm_pkg::DATA_W-1:0] i_value,
    output logic                              o_busy,
    output ssm_pkg::t_ram_req                 o_req_a,
    output ssm_pkg::t_ram_req                 o_req_b,
    input  logic signed [ssm_pkg::DATA_W-1:0] i_head_a,
    input  logic signed [ssm_pkg::DATA_W-1:0] i_head_b,
    output logic                              o_strobe,
    output logic signed [ssm_pkg::DATA_W-1:0] o_merged_value,
    output logic                              o_is_last,
    output logic                              o_overflowed
);

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

    t_state                            r_state;
    logic [ssm_pkg::COUNT_W-1:0]       r_cnt_a, r_cnt_b;
    logic [ssm_pkg::COUNT_W-1:0]       r_ia, r_ib;
    logic [ssm_pkg::COUNT_W-1:0]       n_ia, n_ib;
    logic                              r_ovf;
    logic                              r_strobe;
    logic signed [ssm_pkg::DATA_W-1:0] r_value;
    logic                              r_last;
    logic                              r_ovf_out;

    logic accept, have_a, have_b, take_a, last;
    logic full_a, full_b;

    assign accept = i_start && (r_state == ST_IDLE);
    assign full_a = (r_cnt_a == ssm_pkg::COUNT_W'(ssm_pkg::DEPTH));
    assign full_b = (r_cnt_b == ssm_pkg::COUNT_W'(ssm_pkg::DEPTH));

    // Head compare; A wins only on strict less-than.
    assign have_a = (r_ia < r_cnt_a);
    assign have_b = (r_ib < r_cnt_b);
    assign take_a = (have_a && have_b) ? (i_head_a < i_head_b) : have_a;

    always_comb begin
        if (r_state == ST_MERGE) begin
            n_ia = r_ia + ssm_pkg::COUNT_W'(take_a);
            n_ib = r_ib + ssm_pkg::COUNT_W'(!take_a);
        end else begin
            n_ia = '0;
            n_ib = '0;
        end
    end

    assign last = (n_ia == r_cnt_a) && (n_ib == r_cnt_b);

    // Loads write at the fill count; reads always fetch the next head.
    always_comb begin
        o_req_a.we    = accept && (i_mode == ssm_pkg::MODE_LOAD_A) && !full_a;
        o_req_a.waddr = r_cnt_a[ssm_pkg::ADDR_W-1:0];
        o_req_a.wdata = i_value;
        o_req_a.raddr = n_ia[ssm_pkg::ADDR_W-1:0];
        o_req_b.we    = accept && (i_mode == ssm_pkg::MODE_LOAD_B) && !full_b;
        o_req_b.waddr = r_cnt_b[ssm_pkg::ADDR_W-1:0];
        o_req_b.wdata = i_value;
        o_req_b.raddr = n_ib[ssm_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_ia    <= n_ia;
        r_ib    <= n_ib;
        r_value <= take_a ? i_head_a : i_head_b;
        r_last  <= last;
        r_ovf_out <= r_ovf;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_mode)
                            ssm_pkg::MODE_LOAD_A: begin
                                if (full_a) r_ovf <= 1'b1;
                                else        r_cnt_a <= r_cnt_a + 1'b1;
                            end
                            ssm_pkg::MODE_LOAD_B: begin
                                if (full_b) r_ovf <= 1'b1;
                                else        r_cnt_b <= r_cnt_b + 1'b1;
                            end
                            ssm_pkg::MODE_MERGE: begin
                                if (r_cnt_a == '0 && r_cnt_b == '0) begin
                                    r_ovf <= 1'b0;   // empty merge: no transaction
                                end else begin
                                    r_state <= ST_MERGE;
                                end
                            end
                            default: ;               // unused code
                        endcase
                    end
                end
                ST_MERGE: begin
                    r_strobe <= 1'b1;
                    if (last) begin
                        r_state <= ST_IDLE;
                        r_cnt_a <= '0;
                        r_cnt_b <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_merged_value = r_value;
    assign o_is_last      = r_last;
    assign o_overflowed   = r_ovf_out;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for sorted_sequence_merge (two-way sorted merge).
// Depends on ssm_pkg and the sorted_sequence_merge RTL; needs nothing else to run.
// A scoreboard class predicts every merged word; plain tasks drive the command port.

module tb;

    // Mode code that the block must ignore; the package names only the used three.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int TARGET_ITEMS   = 470;
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction on either port
    localparam int TAIL_CYCLES    = 6;

    localparam logic signed [ssm_pkg::DATA_W-1:0] VALUE_MIN =
        {1'b1, {(ssm_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [ssm_pkg::DATA_W-1:0] VALUE_MAX =
        {1'b0, {(ssm_pkg::DATA_W-1){1'b1}}};

    // One expected word on the result port.
    typedef struct {
        logic signed [ssm_pkg::DATA_W-1:0] value;
        logic                              last;
        logic                              ovf;
    } t_merged_word;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of both lists and the sticky overflow
    // flag, expands each accepted merge into the words it must produce and
    // checks the result port against them in order.
    // ------------------------------------------------------------------
    class merge_scoreboard;
        logic signed [ssm_pkg::DATA_W-1:0] list_a [ssm_pkg::DEPTH];
        logic signed [ssm_pkg::DATA_W-1:0] list_b [ssm_pkg::DEPTH];
        int                                a_fill;
        int                                b_fill;
        logic                              dropped_load;
        t_merged_word                      expected_words [$];
        int                                mismatches;

        function new();
            a_fill       = 0;
            b_fill       = 0;
            dropped_load = 1'b0;
            mismatches   = 0;
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction

        // Called once per accepted command transaction.
        function void note_command(logic [1:0] mode,
                                   logic signed [ssm_pkg::DATA_W-1:0] value);
            int           ia;
            int           ib;
            int           total;
            bit           take_a;
            t_merged_word w;
            case (mode)
                ssm_pkg::MODE_LOAD_A: begin
                    if (a_fill < ssm_pkg::DEPTH) begin
                        list_a[a_fill] = value;
                        a_fill = a_fill + 1;
                    end else begin
                        dropped_load = 1'b1;
                    end
                end
                ssm_pkg::MODE_LOAD_B: begin
                    if (b_fill < ssm_pkg::DEPTH) begin
                        list_b[b_fill] = value;
                        b_fill = b_fill + 1;
                    end else begin
                        dropped_load = 1'b1;
                    end
                end
                ssm_pkg::MODE_MERGE: begin
                    ia    = 0;
                    ib    = 0;
                    total = a_fill + b_fill;
                    for (int k = 0; k < total; k++) begin
                        // A wins only on strict less-than, so ties go to B
                        if (ia < a_fill && ib < b_fill)
                            take_a = (list_a[ia] < list_b[ib]);
                        else
                            take_a = (ia < a_fill);
                        if (take_a) begin
                            w.value = list_a[ia];
                            ia = ia + 1;
                        end else begin
                            w.value = list_b[ib];
                            ib = ib + 1;
                        end
                        w.last = (k == total - 1);
                        w.ovf  = dropped_load;
                        expected_words.push_back(w);
                    end
                    a_fill       = 0;
                    b_fill       = 0;
                    dropped_load = 1'b0;
                end
                default: ;  // unused code: no state change, no result
            endcase
        endfunction

        // Called once per strobed result.
        function void check_result(logic signed [ssm_pkg::DATA_W-1:0] value,
                                   logic last, logic ovf);
            t_merged_word w;
            if (expected_words.size() == 0) begin
                $error("unexpected result: merged_value %0d is_last %0b overflowed %0b",
                       value, last, ovf);
                mismatches = mismatches + 1;
                return;
            end
            w = expected_words.pop_front();
            if (value !== w.value) begin
                $error("merged_value: expected %0d, got %0d", w.value, value);
                mismatches = mismatches + 1;
            end
            if (last !== w.last) begin
                $error("is_last: expected %0b, got %0b", w.last, last);
                mismatches = mismatches + 1;
            end
            if (ovf !== w.ovf) begin
                $error("overflowed: expected %0b, got %0b", w.ovf, ovf);
                mismatches = mismatches + 1;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                              i_clk;
    logic                              i_rst_n = 1'b0;
    logic                              i_start = 1'b0;
    logic [1:0]                        i_mode  = ssm_pkg::MODE_LOAD_A;
    logic signed [ssm_pkg::DATA_W-1:0] i_value = '0;
    logic                              o_busy;
    logic                              o_strobe;
    logic signed [ssm_pkg::DATA_W-1:0] o_merged_value;
    logic                              o_is_last;
    logic                              o_overflowed;

    merge_scoreboard sb;
    int              items_sent = 0;   // load and merge transactions; unused code excluded
    int              idle_cycles = 0;

    sorted_sequence_merge dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_merged_value (o_merged_value),
        .o_is_last      (o_is_last),
        .o_overflowed   (o_overflowed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result port has no backpressure: every strobe is a transaction.
    // Reads right after the edge see pre-edge values, so no race with the DUT.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_merged_value, o_is_last, o_overflowed);
    end

    // Watchdog: a hang shows up as a long run of cycles with no transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks. Each one is entered just after a rising edge and makes at
    // most one assignment to i_start in that time step.
    // ------------------------------------------------------------------

    // Present one command and hold it until the block takes it.
    task automatic issue_command(input logic [1:0] mode,
                                 input logic signed [ssm_pkg::DATA_W-1:0] value);
        i_start <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        sb.note_command(mode, value);
        if (mode != MODE_UNUSED)
            items_sent = items_sent + 1;
    endtask

    // Sender gap: start low, junk on the payload ports.
    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            i_start <= 1'b0;
            i_mode  <= 2'($urandom);
            i_value <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // Hold off until every expected word is back, then let the block settle.
    task automatic wait_for_results();
        i_start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [ssm_pkg::DATA_W-1:0] any_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return VALUE_MIN;
        else if (r == 1)
            return VALUE_MAX;
        else if (r < 6)
            return $signed($urandom_range(0, 15)) - 8;
        else
            return $signed($urandom);
    endfunction

    // Mostly short lists, some long ones, a few that run past capacity.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 6);
        else if (r < 93)
            return $urandom_range(7, ssm_pkg::DEPTH);
        else
            return $urandom_range(ssm_pkg::DEPTH, ssm_pkg::DEPTH + 4);
    endfunction

    // Fill queue with a run, ascending if ordered. Both lists share a base so
    // that their values interleave; a narrow step makes equal heads common.
    task automatic build_run(ref logic signed [ssm_pkg::DATA_W-1:0] run[$], input int len,
                             input longint base, input bit narrow, input bit ordered);
        longint cur;
        cur = base;
        run.delete();
        for (int n = 0; n < len; n++) begin
            if (!ordered) begin
                run.push_back(any_value());
            end else begin
                run.push_back(cur[ssm_pkg::DATA_W-1:0]);
                if (narrow)
                    cur = cur + $urandom_range(0, 2);
                else
                    cur = cur + $urandom_range(0, 1 << $urandom_range(0, 28));
                if (cur > longint'(VALUE_MAX))
                    cur = VALUE_MAX;  // saturate so the run stays ascending
            end
        end
    endtask

    // One load phase and its merge. Loads to A and B interleave at random,
    // with an occasional ignored command thrown in.
    task automatic run_merge_sequence(input int len_a, input int len_b, input bit ordered);
        logic signed [ssm_pkg::DATA_W-1:0] run_a[$];
        logic signed [ssm_pkg::DATA_W-1:0] run_b[$];
        longint                            base;
        bit                                narrow;
        bit                                burst;
        bit                                pick_a;
        int                                r;
        r      = $urandom_range(0, 9);
        narrow = ($urandom_range(0, 2) == 0);
        burst  = ($urandom_range(0, 3) == 0);
        if (r == 0)
            base = VALUE_MIN;
        else if (narrow || r < 4)
            base = $signed($urandom_range(0, 31)) - 16;
        else
            base = longint'($signed($urandom));
        build_run(run_a, len_a, base, narrow, ordered);
        build_run(run_b, len_b, base, narrow, ordered);
        while (run_a.size() + run_b.size() > 0) begin
            if (run_a.size() == 0)
                pick_a = 1'b0;
            else if (run_b.size() == 0)
                pick_a = 1'b1;
            else
                pick_a = $urandom_range(0, 1);
            if (pick_a)
                issue_command(ssm_pkg::MODE_LOAD_A, run_a.pop_front());
            else
                issue_command(ssm_pkg::MODE_LOAD_B, run_b.pop_front());
            sender_gap(pick_gap(burst));
            if ($urandom_range(0, 19) == 0) begin
                issue_command(MODE_UNUSED, $signed($urandom));
                sender_gap(pick_gap(burst));
            end
        end
        issue_command(ssm_pkg::MODE_MERGE, $signed($urandom));
        sender_gap(pick_gap(burst));
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial begin
        int kind;
        sb = new();

        // synchronous reset, applied once
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes on both lists with equal heads at several points, so B
        // must win every tie
        issue_command(ssm_pkg::MODE_LOAD_A, VALUE_MIN);
        issue_command(ssm_pkg::MODE_LOAD_B, VALUE_MIN);
        issue_command(ssm_pkg::MODE_LOAD_A, -1);
        issue_command(ssm_pkg::MODE_LOAD_B, 0);
        issue_command(ssm_pkg::MODE_LOAD_A, 0);
        issue_command(ssm_pkg::MODE_LOAD_B, 5);
        issue_command(ssm_pkg::MODE_LOAD_A, 5);
        issue_command(ssm_pkg::MODE_LOAD_B, 7);
        issue_command(ssm_pkg::MODE_LOAD_B, VALUE_MAX);
        issue_command(ssm_pkg::MODE_LOAD_A, VALUE_MAX);
        issue_command(MODE_UNUSED, -1);      // ignored, must not touch the lists
        issue_command(ssm_pkg::MODE_MERGE, 0);
        issue_command(ssm_pkg::MODE_MERGE, -1);       // both lists empty: no result
        // only A holds data, then only B
        issue_command(ssm_pkg::MODE_LOAD_A, 3);
        issue_command(ssm_pkg::MODE_LOAD_A, 9);
        issue_command(ssm_pkg::MODE_MERGE, 0);
        issue_command(ssm_pkg::MODE_LOAD_B, -42);
        issue_command(ssm_pkg::MODE_MERGE, 0);
        // unsorted input: the same head compare runs, no ordering check
        issue_command(ssm_pkg::MODE_LOAD_A, 3);
        issue_command(ssm_pkg::MODE_LOAD_A, 1);
        issue_command(ssm_pkg::MODE_LOAD_B, 2);
        issue_command(ssm_pkg::MODE_MERGE, 0);
        wait_for_results();  // sender pauses until every expected word is back

        // Both lists full plus dropped loads: largest merge, overflow reported
        run_merge_sequence(ssm_pkg::DEPTH + 2, ssm_pkg::DEPTH + 2, 1'b1);
        wait_for_results();

        // Random: mostly well-formed ascending runs, some unsorted, some noise
        while (items_sent < TARGET_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                run_merge_sequence(pick_length(), pick_length(), 1'b1);
            end else if (kind < 92) begin
                run_merge_sequence(pick_length(), pick_length(), 1'b0);
            end else begin
                // noise: ignored commands and a merge with nothing stored
                repeat ($urandom_range(1, 3)) begin
                    issue_command(MODE_UNUSED, $signed($urandom));
                    sender_gap(pick_gap(1'b0));
                end
                issue_command(ssm_pkg::MODE_MERGE, $signed($urandom));
                sender_gap(pick_gap(1'b0));
            end
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end

        // drain, then a few more cycles to catch stray strobes
        wait_for_results();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
